@@ rtl/rbdr_pkg.sv @@
// Shared types, codes and BCD helper functions for the RTC DST resolver.
package rbdr_pkg;

    typedef enum logic [1:0] {
        MODE_AUTO   = 2'd0,
        MODE_FORCE_ON  = 2'd1,
        MODE_FORCE_OFF = 2'd2,
        MODE_UNUSED    = 2'd3
    } t_dst_mode;

    localparam logic [7:0] MONTH_MARCH   = 8'd3;
    localparam logic [7:0] MONTH_APRIL   = 8'd4;
    localparam logic [7:0] MONTH_SEPT    = 8'd9;
    localparam logic [7:0] MONTH_OCTOBER = 8'd10;
    localparam logic [7:0] DAY_SUNDAY    = 8'd7;
    localparam logic [8:0] MONTH_DAYS    = 9'd31;
    localparam logic [5:0] HOUR_CHANGE_ON  = 6'd2;
    localparam logic [5:0] HOUR_CHANGE_OFF = 6'd3;

    // One snapshot of the clock registers plus the stored flag byte.
    typedef struct packed {
        logic [7:0] seconds_reg;
        logic [7:0] minutes_reg;
        logic [7:0] hours_reg;
        logic [7:0] weekday_reg;
        logic [7:0] date_reg;
        logic [7:0] month_reg;
        logic [7:0] year_reg;
        logic [7:0] stored_flag_reg;
    } t_snapshot;

    typedef struct packed {
        logic [7:0] seconds_bin;
        logic [7:0] minutes_bin;
        logic [5:0] hours_bin;
        logic [7:0] weekday_out;
        logic [7:0] day_bin;
        logic [7:0] month_bin;
        logic [7:0] year_bin;
        logic       dst_active;
        logic       change_announce;
        logic       rewrite_needed;
        logic [7:0] hours_bcd_write;
        logic       flag_write;
    } t_result;

    // Ten times the high nibble plus the low nibble, with no range check.
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] tens;
        tens = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0};
        return tens + {4'h0, b[3:0]};
    endfunction

    // Encodes an hour already reduced below 24.
    function automatic logic [7:0] bcd_encode_hour(input logic [5:0] v);
        logic [5:0] ones;
        logic [1:0] tens;
        if (v >= 6'd20) begin
            tens = 2'd2;
            ones = v - 6'd20;
        end else if (v >= 6'd10) begin
            tens = 2'd1;
            ones = v - 6'd10;
        end else begin
            tens = 2'd0;
            ones = v;
        end
        return {2'b00, tens, ones[3:0]};
    endfunction

    // Remainder by seven: eight is one modulo seven, so octal digits are summed.
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = {2'b00, x[2:0]} + {2'b00, x[5:3]} + {3'b000, x[7:6]};
        s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

@@ rtl/rbdr_resolve.sv @@
// Combinational decode and daylight saving decision for one snapshot.
module rbdr_resolve
    import rbdr_pkg::*;
(
    input  t_snapshot  i_snap,
    input  logic [1:0] i_mode,
    output t_result    o_result
);

    logic [7:0] day;
    logic [7:0] mon;
    logic [5:0] hr;
    logic [3:0] to_sun;
    logic [8:0] day_sum;
    logic       last_week;
    logic       sunday;
    logic       stored;
    logic       dst;
    logic       announce;
    logic       rewrite;
    logic [6:0] hr_fwd;
    logic [6:0] hr_back;
    logic [5:0] hr_shift;

    always_comb begin
        day    = bcd_decode(i_snap.date_reg);
        mon    = bcd_decode(i_snap.month_reg);
        hr     = ({4'b0000, i_snap.hours_reg[5:4]} * 6'd10) + {2'b00, i_snap.hours_reg[3:0]};
        // Days to the next Sunday; a Sunday itself counts a full week.
        to_sun = 4'd7 - {1'b0, mod7(i_snap.weekday_reg)};
        day_sum   = {1'b0, day} + {5'b00000, to_sun};
        last_week = day_sum > MONTH_DAYS;
        sunday    = i_snap.weekday_reg == DAY_SUNDAY;
        stored    = i_snap.stored_flag_reg == 8'd1;

        dst      = 1'b0;
        announce = 1'b0;
        unique case (t_dst_mode'(i_mode))
            MODE_AUTO: begin
                if (mon >= MONTH_APRIL && mon <= MONTH_SEPT) begin
                    dst = 1'b1;
                end else if (mon == MONTH_MARCH) begin
                    if (last_week) begin
                        dst      = !sunday || hr >= HOUR_CHANGE_ON;
                        announce = sunday && hr == HOUR_CHANGE_ON;
                    end
                end else if (mon == MONTH_OCTOBER) begin
                    if (!last_week) begin
                        dst = 1'b1;
                    end else if (sunday && hr < HOUR_CHANGE_OFF && stored) begin
                        // The repeated hour is still summer time until the flag clears.
                        dst      = 1'b1;
                        announce = hr == HOUR_CHANGE_ON;
                    end
                end
            end
            MODE_FORCE_ON:  dst = 1'b1;
            MODE_FORCE_OFF: dst = 1'b0;
            MODE_UNUSED:    dst = 1'b0;
            default:        dst = 1'b0;
        endcase

        rewrite = dst != stored;

        // The decoded hour can reach 45, so the back shift may wrap twice.
        hr_fwd  = {1'b0, hr} + 7'd1;
        hr_back = {1'b0, hr} + 7'd23;
        if (dst) begin
            hr_shift = (hr_fwd >= 7'd24) ? 6'(hr_fwd - 7'd24) : hr_fwd[5:0];
        end else if (hr_back >= 7'd48) begin
            hr_shift = 6'(hr_back - 7'd48);
        end else if (hr_back >= 7'd24) begin
            hr_shift = 6'(hr_back - 7'd24);
        end else begin
            hr_shift = hr_back[5:0];
        end

        o_result.seconds_bin     = bcd_decode(i_snap.seconds_reg);
        o_result.minutes_bin     = bcd_decode(i_snap.minutes_reg);
        o_result.hours_bin       = rewrite ? hr_shift : hr;
        o_result.weekday_out     = i_snap.weekday_reg;
        o_result.day_bin         = day;
        o_result.month_bin       = mon;
        o_result.year_bin        = bcd_decode(i_snap.year_reg);
        o_result.dst_active      = dst;
        o_result.change_announce = announce;
        o_result.rewrite_needed  = rewrite;
        o_result.hours_bcd_write = rewrite ? bcd_encode_hour(hr_shift) : 8'h00;
        o_result.flag_write      = rewrite && dst;
    end

endmodule

@@ rtl/rtc_bcd_dst_resolver_top.sv @@
// Top level of the RTC DST resolver: input register, resolve logic, result register.
//
// Usage: a request on the input channel carries one snapshot of the seven BCD
// clock register bytes and the stored DST flag byte. The block answers each
// request with exactly one result carrying the decoded time, the DST and
// announce flags, and the rewrite values for the hour and flag bytes.
// Both channels use valid and stall; a request moves when valid is high and
// stall is low. The mode register is written over the config channel, whose
// ready is always high; write it only while no request is in flight.
// A request accepted at a clock edge sits in the input register; the result
// register then loads from it and raises result valid, unless the receiver stalls.
// Throughput is one request per cycle while the receiver does not stall, set by the
// two-stage register pipeline. When the receiver stalls, the result register holds;
// an empty input register still takes one more request, and only then is input stall raised.
// Synchronous reset empties both stages and sets the mode to automatic.
module rtc_bcd_dst_resolver_top
    import rbdr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_seconds_reg,
    input  logic [7:0] i_minutes_reg,
    input  logic [7:0] i_hours_reg,
    input  logic [7:0] i_weekday_reg,
    input  logic [7:0] i_date_reg,
    input  logic [7:0] i_month_reg,
    input  logic [7:0] i_year_reg,
    input  logic [7:0] i_stored_flag_reg,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_seconds_bin,
    output logic [7:0] o_minutes_bin,
    output logic [5:0] o_hours_bin,
    output logic [7:0] o_weekday_out,
    output logic [7:0] o_day_bin,
    output logic [7:0] o_month_bin,
    output logic [7:0] o_year_bin,
    output logic       o_dst_active,
    output logic       o_change_announce,
    output logic       o_rewrite_needed,
    output logic [7:0] o_hours_bcd_write,
    output logic       o_flag_write
);

    logic [1:0] r_mode;
    logic       r_s1_valid;
    t_snapshot  r_snap;
    logic       r_s2_valid;
    t_result    r_result;
    t_result    n_result;
    logic       s2_load;
    logic       s1_load;

    assign o_cfg_ready = 1'b1;

    assign s2_load    = !r_s2_valid || !i_out_stall;
    assign s1_load    = !r_s1_valid || s2_load;
    assign o_in_stall = !s1_load;

    rbdr_resolve u_resolve (
        .i_snap   (r_snap),
        .i_mode   (r_mode),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_AUTO;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            if (s1_load) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_snap <= '{seconds_reg:     i_seconds_reg,
                        minutes_reg:     i_minutes_reg,
                        hours_reg:       i_hours_reg,
                        weekday_reg:     i_weekday_reg,
                        date_reg:        i_date_reg,
                        month_reg:       i_month_reg,
                        year_reg:        i_year_reg,
                        stored_flag_reg: i_stored_flag_reg};
        end
        if (s2_load && r_s1_valid) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid       = r_s2_valid;
    assign o_seconds_bin     = r_result.seconds_bin;
    assign o_minutes_bin     = r_result.minutes_bin;
    assign o_hours_bin       = r_result.hours_bin;
    assign o_weekday_out     = r_result.weekday_out;
    assign o_day_bin         = r_result.day_bin;
    assign o_month_bin       = r_result.month_bin;
    assign o_year_bin        = r_result.year_bin;
    assign o_dst_active      = r_result.dst_active;
    assign o_change_announce = r_result.change_announce;
    assign o_rewrite_needed  = r_result.rewrite_needed;
    assign o_hours_bcd_write = r_result.hours_bcd_write;
    assign o_flag_write      = r_result.flag_write;

`ifndef SYNTHESIS
    // Input stall only rises when both stages hold a request.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_s2_valid))
        else $error("input stalled with a free stage");

    // A changeover announcement only happens while DST still applies.
    a_announce_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_change_announce) |-> o_dst_active)
        else $error("announce without DST");

    // Without a rewrite the write-back fields stay zero.
    a_no_rewrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rewrite_needed) |-> (o_hours_bcd_write == 8'h00 && !o_flag_write))
        else $error("write-back fields set without rewrite");

    // A rewrite always leaves an hour below 24 and the flag equal to DST.
    a_rewrite_hour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rewrite_needed) |->
            (o_hours_bin < 6'd24 && o_flag_write == o_dst_active))
        else $error("rewrite hour or flag inconsistent");
`endif

endmodule
